/* src/tfd_pkg.sv */
package tfd_pkg;

    typedef struct packed {
        logic [63:0] texel_high;
        logic [63:0] texel_low;
    } t_texel_in;

    typedef struct packed {
        logic [31:0] red;
        logic [31:0] green;
        logic [31:0] blue;
        logic [31:0] alpha;
    } t_texel_out;

    localparam logic [4:0] FMT_R8_UNORM      = 5'd0;
    localparam logic [4:0] FMT_RG8_UNORM     = 5'd1;
    localparam logic [4:0] FMT_RG8_SNORM     = 5'd2;
    localparam logic [4:0] FMT_RGBA8_UNORM   = 5'd3;
    localparam logic [4:0] FMT_RGBA8_SNORM   = 5'd4;
    localparam logic [4:0] FMT_BGRA8_UNORM   = 5'd5;
    localparam logic [4:0] FMT_BGRA8_SNORM   = 5'd6;
    localparam logic [4:0] FMT_A2B10G10R10   = 5'd7;
    localparam logic [4:0] FMT_A2R10G10B10   = 5'd8;
    localparam logic [4:0] FMT_B10G11R11_UF  = 5'd9;
    localparam logic [4:0] FMT_E5B9G9R9_UF   = 5'd10;
    localparam logic [4:0] FMT_R16_UNORM     = 5'd11;
    localparam logic [4:0] FMT_R16_HALF      = 5'd12;
    localparam logic [4:0] FMT_RG16_UNORM    = 5'd13;
    localparam logic [4:0] FMT_RG16_SNORM    = 5'd14;
    localparam logic [4:0] FMT_RG16_HALF     = 5'd15;
    localparam logic [4:0] FMT_RGBA16_UNORM  = 5'd16;
    localparam logic [4:0] FMT_RGBA16_SNORM  = 5'd17;
    localparam logic [4:0] FMT_RGBA16_HALF   = 5'd18;
    localparam logic [4:0] FMT_R32_FLOAT     = 5'd19;
    localparam logic [4:0] FMT_R32_UINT      = 5'd20;
    localparam logic [4:0] FMT_RG32_FLOAT    = 5'd21;
    localparam logic [4:0] FMT_RGBA32_FLOAT  = 5'd22;
    localparam logic [4:0] FMT_UNDEFINED     = 5'd23;

    localparam logic [31:0] ONE_BITS     = 32'h3f80_0000;
    localparam logic [31:0] NEG_ONE_BITS = 32'hbf80_0000;
    localparam logic [31:0] INF_BITS     = 32'h7f80_0000;
    localparam logic [31:0] QNAN_BITS    = 32'h7fc0_0000;

    // A value v / (2^n - 1) is the binary fraction 0.vvv... with v repeated.
    // The stream holds that fraction; the leading one sits in its top 16 bits.
    // The tail never ends in a tie, so rounding needs only the guard bit.
    function automatic logic [31:0] rep_to_f32(input logic [47:0] s, input logic neg);
        logic [4:0]  lz;
        logic        found;
        logic [47:0] sh;
        logic [24:0] m;
        logic [7:0]  ex;
        lz = 5'd0;
        found = 1'b0;
        for (int i = 0; i < 16; i++) begin
            if (!found && s[47-i]) begin
                lz = i[4:0];
                found = 1'b1;
            end
        end
        sh = s << lz;
        m = {1'b0, sh[47:24]} + {24'd0, sh[23]};
        ex = 8'd126 - {3'b000, lz};
        if (!found) begin
            return 32'h0;
        end
        if (m[24]) begin
            return {neg, ex + 8'd1, 23'h0};
        end
        return {neg, ex, m[22:0]};
    endfunction

    function automatic logic [31:0] unorm2(input logic [1:0] v);
        return rep_to_f32({24{v}}, 1'b0);
    endfunction

    function automatic logic [31:0] unorm8(input logic [7:0] v);
        return rep_to_f32({6{v}}, 1'b0);
    endfunction

    function automatic logic [31:0] unorm10(input logic [9:0] v);
        logic [49:0] t;
        t = {5{v}};
        return rep_to_f32(t[49:2], 1'b0);
    endfunction

    function automatic logic [31:0] unorm16(input logic [15:0] v);
        return rep_to_f32({3{v}}, 1'b0);
    endfunction

    function automatic logic [31:0] snorm8(input logic [7:0] v);
        logic [7:0]  mag;
        logic [48:0] t;
        mag = v[7] ? (8'd0 - v) : v;
        t = {7{mag[6:0]}};
        if (v == 8'h80) begin
            return NEG_ONE_BITS;
        end
        return rep_to_f32(t[48:1], v[7]);
    endfunction

    function automatic logic [31:0] snorm16(input logic [15:0] v);
        logic [15:0] mag;
        logic [59:0] t;
        mag = v[15] ? (16'd0 - v) : v;
        t = {4{mag[14:0]}};
        if (v == 16'h8000) begin
            return NEG_ONE_BITS;
        end
        return rep_to_f32(t[59:12], v[15]);
    endfunction

    // m * 2^k with a nonzero m of at most ten bits; eb is 127 + k.
    function automatic logic [31:0] exact_small(input logic [9:0] m, input logic [7:0] eb);
        logic [3:0]  p;
        logic [23:0] t;
        p = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (m[i]) begin
                p = i[3:0];
            end
        end
        t = {1'b0, m, 13'd0} << (4'd10 - p);
        if (m == 10'd0) begin
            return 32'h0;
        end
        return {1'b0, eb + {4'd0, p}, t[22:0]};
    endfunction

    function automatic logic [31:0] half_to_f32(input logic [15:0] h);
        logic [4:0]  ex;
        logic [9:0]  man;
        logic [31:0] r;
        ex = h[14:10];
        man = h[9:0];
        if (ex == 5'd0) begin
            r = exact_small(man, 8'd103);
        end else if (ex == 5'h1f) begin
            r = (man == 10'd0) ? INF_BITS : QNAN_BITS;
        end else begin
            r = {1'b0, {3'b000, ex} + 8'd112, man, 13'd0};
        end
        return {h[15], r[30:0]};
    endfunction

    function automatic logic [31:0] packed6(input logic [5:0] man, input logic [4:0] ex);
        if (ex == 5'd0) begin
            return exact_small({4'd0, man}, 8'd107);
        end
        if (ex == 5'h1f) begin
            return (man == 6'd0) ? INF_BITS : QNAN_BITS;
        end
        return {1'b0, {3'b000, ex} + 8'd112, man, 17'd0};
    endfunction

    function automatic logic [31:0] packed5(input logic [4:0] man, input logic [4:0] ex);
        if (ex == 5'd0) begin
            return exact_small({5'd0, man}, 8'd108);
        end
        if (ex == 5'h1f) begin
            return (man == 5'd0) ? INF_BITS : QNAN_BITS;
        end
        return {1'b0, {3'b000, ex} + 8'd112, man, 18'd0};
    endfunction

    function automatic logic [31:0] uint_to_f32(input logic [31:0] v);
        logic [4:0]  lz;
        logic        found;
        logic [31:0] sh;
        logic        up;
        logic [24:0] m;
        logic [7:0]  ex;
        lz = 5'd0;
        found = 1'b0;
        for (int i = 0; i < 32; i++) begin
            if (!found && v[31-i]) begin
                lz = i[4:0];
                found = 1'b1;
            end
        end
        sh = v << lz;
        up = sh[7] & ((|sh[6:0]) | sh[8]);
        m = {1'b0, sh[31:8]} + {24'd0, up};
        ex = 8'd158 - {3'b000, lz};
        if (!found) begin
            return 32'h0;
        end
        if (m[24]) begin
            return {1'b0, ex + 8'd1, 23'h0};
        end
        return {1'b0, ex, m[22:0]};
    endfunction

endpackage

/* src/texel_format_decoder.sv */
// Channel  | Direction | Handshake            | Payload
// input    | in        | i_valid / o_stall    | i_data (t_texel_in)
// output   | out       | o_valid / i_stall    | o_data (t_texel_out)
// config   | in        | i_cfg_we             | i_cfg_wdata (format class)
//
// An accepted item is captured in the input register, then passes the decode
// logic into the result register, from which it leaves. One item is accepted
// every cycle while the output is not stalled. A stall on a full result
// register holds it, and o_stall rises when the input register is also
// occupied. Reset empties both stages and sets the format class to undefined.
module texel_format_decoder import tfd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [4:0] i_cfg_wdata,
    input  logic       i_valid,
    input  t_texel_in  i_data,
    output logic       o_stall,
    output logic       o_valid,
    output t_texel_out o_data,
    input  logic       i_stall
);

    logic [4:0] r_fmt;
    logic       r_in_v;
    t_texel_in  r_in;
    logic       r_out_v;
    t_texel_out r_out;
    t_texel_out n_out;
    logic       out_free;
    logic       in_free;

    tfd_convert u_convert (
        .i_fmt    (r_fmt),
        .i_texel  (r_in),
        .o_result (n_out)
    );

    assign out_free = !r_out_v || !i_stall;
    assign in_free  = !r_in_v || out_free;
    assign o_stall  = !in_free;
    assign o_valid  = r_out_v;
    assign o_data   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= FMT_UNDEFINED;
        end else if (i_cfg_we) begin
            r_fmt <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (in_free) begin
                r_in_v <= i_valid;
            end
            if (out_free) begin
                r_out_v <= r_in_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_free && i_valid) begin
            r_in <= i_data;
        end
        if (out_free && r_in_v) begin
            r_out <= n_out;
        end
    end

endmodule

/* src/tfd_convert.sv */
module tfd_convert import tfd_pkg::*; (
    input  logic [4:0] i_fmt,
    input  t_texel_in  i_texel,
    output t_texel_out o_result
);

    logic [63:0] lo;
    logic [63:0] hi;
    logic [31:0] p;
    logic [7:0]  ebase;

    assign lo = i_texel.texel_low;
    assign hi = i_texel.texel_high;
    assign p = lo[31:0];
    assign ebase = 8'd103 + {3'b000, p[31:27]};

    always_comb begin
        o_result.red   = 32'h0;
        o_result.green = 32'h0;
        o_result.blue  = 32'h0;
        o_result.alpha = ONE_BITS;
        case (i_fmt)
            FMT_R8_UNORM: begin
                o_result.red = unorm8(lo[7:0]);
            end
            FMT_RG8_UNORM: begin
                o_result.red   = unorm8(lo[7:0]);
                o_result.green = unorm8(lo[15:8]);
            end
            FMT_RG8_SNORM: begin
                o_result.red   = snorm8(lo[7:0]);
                o_result.green = snorm8(lo[15:8]);
            end
            FMT_RGBA8_UNORM: begin
                o_result.red   = unorm8(lo[7:0]);
                o_result.green = unorm8(lo[15:8]);
                o_result.blue  = unorm8(lo[23:16]);
                o_result.alpha = unorm8(lo[31:24]);
            end
            FMT_RGBA8_SNORM: begin
                o_result.red   = snorm8(lo[7:0]);
                o_result.green = snorm8(lo[15:8]);
                o_result.blue  = snorm8(lo[23:16]);
                o_result.alpha = snorm8(lo[31:24]);
            end
            FMT_BGRA8_UNORM: begin
                o_result.red   = unorm8(lo[23:16]);
                o_result.green = unorm8(lo[15:8]);
                o_result.blue  = unorm8(lo[7:0]);
                o_result.alpha = unorm8(lo[31:24]);
            end
            FMT_BGRA8_SNORM: begin
                o_result.red   = snorm8(lo[23:16]);
                o_result.green = snorm8(lo[15:8]);
                o_result.blue  = snorm8(lo[7:0]);
                o_result.alpha = snorm8(lo[31:24]);
            end
            FMT_A2B10G10R10: begin
                o_result.red   = unorm10(p[9:0]);
                o_result.green = unorm10(p[19:10]);
                o_result.blue  = unorm10(p[29:20]);
                o_result.alpha = unorm2(p[31:30]);
            end
            FMT_A2R10G10B10: begin
                o_result.red   = unorm10(p[29:20]);
                o_result.green = unorm10(p[19:10]);
                o_result.blue  = unorm10(p[9:0]);
                o_result.alpha = unorm2(p[31:30]);
            end
            FMT_B10G11R11_UF: begin
                o_result.red   = packed6(p[5:0], p[10:6]);
                o_result.green = packed6(p[16:11], p[21:17]);
                o_result.blue  = packed5(p[26:22], p[31:27]);
            end
            FMT_E5B9G9R9_UF: begin
                o_result.red   = exact_small({1'b0, p[8:0]}, ebase);
                o_result.green = exact_small({1'b0, p[17:9]}, ebase);
                o_result.blue  = exact_small({1'b0, p[26:18]}, ebase);
            end
            FMT_R16_UNORM: begin
                o_result.red = unorm16(lo[15:0]);
            end
            FMT_R16_HALF: begin
                o_result.red = half_to_f32(lo[15:0]);
            end
            FMT_RG16_UNORM: begin
                o_result.red   = unorm16(lo[15:0]);
                o_result.green = unorm16(lo[31:16]);
            end
            FMT_RG16_SNORM: begin
                o_result.red   = snorm16(lo[15:0]);
                o_result.green = snorm16(lo[31:16]);
            end
            FMT_RG16_HALF: begin
                o_result.red   = half_to_f32(lo[15:0]);
                o_result.green = half_to_f32(lo[31:16]);
            end
            FMT_RGBA16_UNORM: begin
                o_result.red   = unorm16(lo[15:0]);
                o_result.green = unorm16(lo[31:16]);
                o_result.blue  = unorm16(lo[47:32]);
                o_result.alpha = unorm16(lo[63:48]);
            end
            FMT_RGBA16_SNORM: begin
                o_result.red   = snorm16(lo[15:0]);
                o_result.green = snorm16(lo[31:16]);
                o_result.blue  = snorm16(lo[47:32]);
                o_result.alpha = snorm16(lo[63:48]);
            end
            FMT_RGBA16_HALF: begin
                o_result.red   = half_to_f32(lo[15:0]);
                o_result.green = half_to_f32(lo[31:16]);
                o_result.blue  = half_to_f32(lo[47:32]);
                o_result.alpha = half_to_f32(lo[63:48]);
            end
            FMT_R32_FLOAT: begin
                o_result.red = p;
            end
            FMT_R32_UINT: begin
                o_result.red = uint_to_f32(p);
            end
            FMT_RG32_FLOAT: begin
                o_result.red   = p;
                o_result.green = lo[63:32];
            end
            FMT_RGBA32_FLOAT: begin
                o_result.red   = p;
                o_result.green = lo[63:32];
                o_result.blue  = hi[31:0];
                o_result.alpha = hi[63:32];
            end
            default: begin
                o_result.alpha = ONE_BITS;
            end
        endcase
    end

endmodule

/* bench/texel_checker.sv */
module texel_checker import tfd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [4:0] i_cfg_wdata,
    input  logic       i_in_valid,
    input  t_texel_in  i_in_data,
    input  logic       i_in_stall,
    input  logic       i_out_valid,
    input  t_texel_out i_out_data,
    input  logic       i_out_stall,
    output int         o_errors,
    output int         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [4:0] layout;
    t_texel_out expected_texels[$];

    // Correctly rounded num / den as a single, round to nearest even.
    function automatic logic [31:0] ratio_bits(longint unsigned num, longint unsigned den,
                                               bit neg);
        int k;
        longint unsigned n, d, q, r;
        logic [7:0] ex;
        if (num == 0) begin
            return 32'h0;
        end
        n = num;
        d = den;
        k = 0;
        while (n < d) begin
            n = n << 1;
            k++;
        end
        while (n >= (d << 1)) begin
            d = d << 1;
            k--;
        end
        q = (n << 23) / d;
        r = (n << 23) % d;
        if ((2 * r > d) || ((2 * r == d) && q[0])) begin
            q++;
        end
        if (q == (64'd1 << 24)) begin
            q = 64'd1 << 23;
            k--;
        end
        ex = 8'(127 - k);
        return {neg, ex, q[22:0]};
    endfunction

    function automatic logic [31:0] scaled_bits(longint unsigned m, int e);
        if (e >= 0) begin
            return ratio_bits(m << e, 1, 1'b0);
        end
        return ratio_bits(m, 64'd1 << (-e), 1'b0);
    endfunction

    function automatic logic [31:0] snorm_value(int v, int div);
        longint unsigned mag;
        mag = (v < 0) ? -v : v;
        if (v < 0 && mag > div) begin
            return NEG_ONE_BITS;
        end
        return ratio_bits(mag, div, v < 0);
    endfunction

    function automatic logic [31:0] half_value(logic [15:0] h);
        logic [31:0] r;
        if (h[14:10] == 5'd0) begin
            r = scaled_bits(h[9:0], -24);
        end else if (h[14:10] == 5'h1f) begin
            r = (h[9:0] == 10'd0) ? INF_BITS : QNAN_BITS;
        end else begin
            r = scaled_bits({1'b1, h[9:0]}, int'(h[14:10]) - 25);
        end
        return r | {h[15], 31'd0};
    endfunction

    function automatic logic [31:0] small_float(logic [5:0] man, logic [4:0] ex, int mbits);
        if (ex == 5'd0) begin
            return scaled_bits(man, -14 - mbits);
        end
        if (ex == 5'h1f) begin
            return (man == 6'd0) ? INF_BITS : QNAN_BITS;
        end
        return scaled_bits(man + (1 << mbits), int'(ex) - 15 - mbits);
    endfunction

    function automatic t_texel_out decode_texel(t_texel_in t, logic [4:0] fmt);
        t_texel_out o;
        logic [7:0]  b[8];
        logic [15:0] w[4];
        logic [31:0] p;
        logic [31:0] c[4];
        int e;
        for (int i = 0; i < 8; i++) b[i] = t.texel_low[8*i +: 8];
        for (int i = 0; i < 4; i++) w[i] = t.texel_low[16*i +: 16];
        p = t.texel_low[31:0];
        c[0] = 32'h0;
        c[1] = 32'h0;
        c[2] = 32'h0;
        c[3] = ONE_BITS;
        case (fmt)
            FMT_R8_UNORM: c[0] = ratio_bits(b[0], 255, 1'b0);
            FMT_RG8_UNORM: begin
                c[0] = ratio_bits(b[0], 255, 1'b0);
                c[1] = ratio_bits(b[1], 255, 1'b0);
            end
            FMT_RG8_SNORM: begin
                c[0] = snorm_value($signed(b[0]), 127);
                c[1] = snorm_value($signed(b[1]), 127);
            end
            FMT_RGBA8_UNORM: for (int i = 0; i < 4; i++) c[i] = ratio_bits(b[i], 255, 1'b0);
            FMT_RGBA8_SNORM: for (int i = 0; i < 4; i++) c[i] = snorm_value($signed(b[i]), 127);
            FMT_BGRA8_UNORM: begin
                c[0] = ratio_bits(b[2], 255, 1'b0);
                c[1] = ratio_bits(b[1], 255, 1'b0);
                c[2] = ratio_bits(b[0], 255, 1'b0);
                c[3] = ratio_bits(b[3], 255, 1'b0);
            end
            FMT_BGRA8_SNORM: begin
                c[0] = snorm_value($signed(b[2]), 127);
                c[1] = snorm_value($signed(b[1]), 127);
                c[2] = snorm_value($signed(b[0]), 127);
                c[3] = snorm_value($signed(b[3]), 127);
            end
            FMT_A2B10G10R10: begin
                c[0] = ratio_bits(p[9:0], 1023, 1'b0);
                c[1] = ratio_bits(p[19:10], 1023, 1'b0);
                c[2] = ratio_bits(p[29:20], 1023, 1'b0);
                c[3] = ratio_bits(p[31:30], 3, 1'b0);
            end
            FMT_A2R10G10B10: begin
                c[0] = ratio_bits(p[29:20], 1023, 1'b0);
                c[1] = ratio_bits(p[19:10], 1023, 1'b0);
                c[2] = ratio_bits(p[9:0], 1023, 1'b0);
                c[3] = ratio_bits(p[31:30], 3, 1'b0);
            end
            FMT_B10G11R11_UF: begin
                c[0] = small_float(p[5:0], p[10:6], 6);
                c[1] = small_float(p[16:11], p[21:17], 6);
                c[2] = small_float({1'b0, p[26:22]}, p[31:27], 5);
            end
            FMT_E5B9G9R9_UF: begin
                e = int'(p[31:27]) - 24;
                c[0] = scaled_bits(p[8:0], e);
                c[1] = scaled_bits(p[17:9], e);
                c[2] = scaled_bits(p[26:18], e);
            end
            FMT_R16_UNORM: c[0] = ratio_bits(w[0], 65535, 1'b0);
            FMT_R16_HALF: c[0] = half_value(w[0]);
            FMT_RG16_UNORM: begin
                c[0] = ratio_bits(w[0], 65535, 1'b0);
                c[1] = ratio_bits(w[1], 65535, 1'b0);
            end
            FMT_RG16_SNORM: begin
                c[0] = snorm_value($signed(w[0]), 32767);
                c[1] = snorm_value($signed(w[1]), 32767);
            end
            FMT_RG16_HALF: begin
                c[0] = half_value(w[0]);
                c[1] = half_value(w[1]);
            end
            FMT_RGBA16_UNORM: for (int i = 0; i < 4; i++) c[i] = ratio_bits(w[i], 65535, 1'b0);
            FMT_RGBA16_SNORM: for (int i = 0; i < 4; i++) c[i] = snorm_value($signed(w[i]), 32767);
            FMT_RGBA16_HALF: for (int i = 0; i < 4; i++) c[i] = half_value(w[i]);
            FMT_R32_FLOAT: c[0] = p;
            FMT_R32_UINT: c[0] = ratio_bits(p, 1, 1'b0);
            FMT_RG32_FLOAT: begin
                c[0] = p;
                c[1] = t.texel_low[63:32];
            end
            FMT_RGBA32_FLOAT: begin
                c[0] = p;
                c[1] = t.texel_low[63:32];
                c[2] = t.texel_high[31:0];
                c[3] = t.texel_high[63:32];
            end
            default: ;
        endcase
        o.red = c[0];
        o.green = c[1];
        o.blue = c[2];
        o.alpha = c[3];
        return o;
    endfunction

    assign o_pending = expected_texels.size();

    always @(posedge i_clk) begin
        t_texel_out want;
        if (!i_rst_n) begin
            layout <= FMT_UNDEFINED;
            o_errors <= 0;
        end else begin
            if (i_cfg_we) begin
                layout <= i_cfg_wdata;
            end
            if (i_in_valid && !i_in_stall) begin
                expected_texels.push_back(decode_texel(i_in_data, layout));
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_texels.size() == 0) begin
                    $display("%0t: unexpected item, actual %h", $time, i_out_data);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_texels.pop_front();
                    if (want !== i_out_data) begin
                        $display("%0t: mismatch, expected %h, actual %h",
                                 $time, want, i_out_data);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

/* bench/testbench.sv */
module testbench;
    import tfd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [4:0] i_cfg_wdata = 5'd0;
    logic       i_valid = 1'b0;
    t_texel_in  i_data = '0;
    logic       o_stall;
    logic       o_valid;
    t_texel_out o_data;
    logic       i_stall = 1'b0;
    int         errors;
    int         pending;
    int         idle_cycles = 0;
    int         stall_mode = 0;

    texel_format_decoder dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_valid(i_valid), .i_data(i_data), .o_stall(o_stall),
        .o_valid(o_valid), .o_data(o_data), .i_stall(i_stall)
    );

    texel_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid(i_valid), .i_in_data(i_data), .i_in_stall(o_stall),
        .i_out_valid(o_valid), .i_out_data(o_data), .i_out_stall(i_stall),
        .o_errors(errors), .o_pending(pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if ($urandom_range(0, 63) == 0) begin
            stall_mode <= $urandom_range(0, 3);
        end
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 3) == 0);
            2: i_stall <= ($urandom_range(0, 1) == 0);
            default: i_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles > 3000) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_texel(logic [63:0] lo, logic [63:0] hi);
        i_valid <= 1'b1;
        i_data <= '{texel_high: hi, texel_low: lo};
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic pause_input(int n);
        i_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic set_layout(logic [4:0] fmt);
        pause_input(1);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= fmt;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hffff;
            2: return {8'h80, 8'($urandom)};
            3: return {8'($urandom), 8'h80};
            4: return {1'($urandom), 5'h1f, 10'($urandom)};
            5: return {1'($urandom), 5'h00, 10'($urandom)};
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [63:0] pick_half_texel();
        return {pick_word(), pick_word(), pick_word(), pick_word()};
    endfunction

    initial begin
        logic [4:0] fmt;
        int n;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_texel(64'h0123_4567_89ab_cdef, 64'hffff_ffff_ffff_ffff);
        set_layout(FMT_RGBA8_SNORM);
        send_texel(64'h0000_0000_8180_7f00, 64'h0);
        send_texel(64'hffff_ffff_ffff_ffff, 64'h0);
        set_layout(FMT_RGBA16_HALF);
        send_texel(64'h7c00_fe01_8000_03ff, 64'h0);
        send_texel(64'hfc00_7bff_0001_0400, 64'h0);
        set_layout(FMT_RGBA16_SNORM);
        send_texel(64'h8000_7fff_8001_ffff, 64'h0);
        set_layout(FMT_B10G11R11_UF);
        send_texel(64'hffff_ffff, 64'h0);
        send_texel(64'hf83e_0fc0, 64'h0);
        set_layout(FMT_E5B9G9R9_UF);
        send_texel(64'hffff_ffff, 64'h0);
        send_texel(64'h07ff_ffff, 64'h0);
        set_layout(FMT_R32_UINT);
        send_texel(64'hffff_ffff, 64'h0);
        send_texel(64'h0100_0001, 64'h0);
        set_layout(FMT_A2R10G10B10);
        send_texel(64'hffff_ffff, 64'h0);
        set_layout(FMT_R8_UNORM);
        send_texel(64'h0, 64'h0);
        send_texel(64'hff, 64'h0);
        set_layout(5'd31);
        send_texel(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff);

        for (int phase = 0; phase < 60; phase++) begin
            if (phase == 0) fmt = FMT_R8_UNORM;
            else if (phase == 1) fmt = 5'd31;
            else if (phase == 2) fmt = FMT_RGBA32_FLOAT;
            else fmt = 5'($urandom_range(0, 31));
            set_layout(fmt);
            n = 0;
            while (n < 30) begin
                if ($urandom_range(0, 3) == 0) begin
                    pause_input($urandom_range(1, 6));
                end
                for (int k = $urandom_range(1, 12); k > 0 && n < 30; k--) begin
                    if ($urandom_range(0, 1) == 0) begin
                        send_texel({$urandom, $urandom}, {$urandom, $urandom});
                    end else begin
                        send_texel(pick_half_texel(), pick_half_texel());
                    end
                    n++;
                end
            end
        end

        pause_input(1);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

/* files.f */
src/tfd_pkg.sv
src/tfd_convert.sv
src/texel_format_decoder.sv
bench/texel_checker.sv
bench/testbench.sv
